// ----- rtl/core/dtsb_pkg.sv -----
package dtsb_pkg;

  typedef logic signed [15:0] s16_t;
  typedef logic signed [16:0] cmp_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } dtsb_in_t;

  typedef struct packed {
    logic signed [15:0] m_right_x;
    logic signed [15:0] m_right_y;
    logic signed [15:0] m_right_z;
    logic signed [15:0] m_up_x;
    logic signed [15:0] m_up_y;
    logic signed [15:0] m_up_z;
    logic signed [15:0] m_front_x;
    logic signed [15:0] m_front_y;
    logic signed [15:0] m_front_z;
    logic signed [15:0] unit_front_x;
    logic signed [15:0] unit_front_y;
    logic signed [15:0] unit_front_z;
  } dtsb_out_t;

  // tilted up vector (0.001, 1, 0) in q1.14
  localparam int TILT_UX    = 16;
  localparam int TILT_UY    = 16384;
  localparam int Q14_ONE    = 16384;
  localparam int ROUND_HALF = 8192;

  localparam int DIV_STAGES  = 31;
  localparam int SQRT_STAGES = 16;
  localparam int NORM_LAT    = DIV_STAGES + SQRT_STAGES + 3;
  localparam int TOTAL_LAT   = 2 * NORM_LAT + 7;

endpackage

// ----- rtl/core/dtsb_if.sv -----
interface dtsb_in_if;
  import dtsb_pkg::*;
  logic     valid;
  logic     ready;
  dtsb_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dtsb_out_if;
  import dtsb_pkg::*;
  logic      valid;
  logic      ready;
  dtsb_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/dtsb_div3.sv -----
module dtsb_div3 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] vsq_i [3],
  input  logic [31:0] s_i,
  output logic [30:0] q_o [3]
);
  import dtsb_pkg::*;

  // quotient of (vsq << 30) / s, one bit per stage, three lanes share s
  logic [31:0] r_q [DIV_STAGES-1][3];
  logic [31:0] r_d [DIV_STAGES-1][3];
  logic [30:0] q_q [DIV_STAGES][3];
  logic [30:0] q_d [DIV_STAGES][3];
  logic [31:0] d_q [DIV_STAGES-1];
  logic [31:0] d_d [DIV_STAGES-1];

  always_comb begin
    logic [32:0] t;
    logic        ge;
    d_d[0] = s_i;
    for (int k = 0; k < 3; k++) begin
      t         = {2'b00, vsq_i[k]};
      ge        = (t >= {1'b0, s_i});
      r_d[0][k] = ge ? 32'(t - {1'b0, s_i}) : t[31:0];
      q_d[0][k] = {30'd0, ge};
    end
    for (int i = 1; i < DIV_STAGES; i++) begin
      for (int k = 0; k < 3; k++) begin
        t         = {r_q[i-1][k], 1'b0};
        ge        = (t >= {1'b0, d_q[i-1]});
        q_d[i][k] = {q_q[i-1][k][29:0], ge};
        if (i < DIV_STAGES - 1) begin
          r_d[i][k] = ge ? 32'(t - {1'b0, d_q[i-1]}) : t[31:0];
        end
      end
      if (i < DIV_STAGES - 1) begin
        d_d[i] = d_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      q_q <= q_d;
      d_q <= d_d;
    end
  end

  assign q_o = q_q[DIV_STAGES-1];

endmodule

// ----- rtl/core/dtsb_isqrt3.sv -----
module dtsb_isqrt3 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] x_i [3],
  output logic [15:0] m_o [3]
);
  import dtsb_pkg::*;

  // floor square root, one result bit per stage, msb first
  logic [30:0] x_q [SQRT_STAGES-1][3];
  logic [30:0] x_d [SQRT_STAGES-1][3];
  logic [15:0] m_q [SQRT_STAGES][3];
  logic [15:0] m_d [SQRT_STAGES][3];

  always_comb begin
    logic [15:0] trial;
    logic [31:0] sq;
    for (int k = 0; k < 3; k++) begin
      trial     = 16'h8000;
      sq        = 32'(trial) * 32'(trial);
      m_d[0][k] = (sq <= 32'(x_i[k])) ? trial : 16'd0;
      x_d[0][k] = x_i[k];
    end
    for (int i = 1; i < SQRT_STAGES; i++) begin
      for (int k = 0; k < 3; k++) begin
        trial     = m_q[i-1][k] | (16'd1 << (SQRT_STAGES - 1 - i));
        sq        = 32'(trial) * 32'(trial);
        m_d[i][k] = (sq <= 32'(x_q[i-1][k])) ? trial : m_q[i-1][k];
        if (i < SQRT_STAGES - 1) begin
          x_d[i][k] = x_q[i-1][k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      m_q <= m_d;
    end
  end

  assign m_o = m_q[SQRT_STAGES-1];

endmodule

// ----- rtl/core/dtsb_norm3.sv -----
module dtsb_norm3 (
  input  logic            clk_i,
  input  logic            en_i,
  input  dtsb_pkg::cmp_t  c_i [3],
  output dtsb_pkg::s16_t  u_o [3]
);
  import dtsb_pkg::*;

  localparam int SIDE_DLY = DIV_STAGES + SQRT_STAGES;

  logic [16:0] mag [3];
  logic [30:0] sq_q [3];
  logic [2:0]  neg_a_q;
  logic [30:0] vsq_q [3];
  logic [31:0] s_q;
  logic [31:0] s_d;
  logic [3:0]  side_q [SIDE_DLY+1];
  logic [30:0] quo [3];
  logic [15:0] root [3];
  s16_t        u_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = c_i[k][16] ? 17'(-c_i[k]) : 17'(c_i[k]);
    end
    s_d = 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
  end

  // squares, then sum of squares with the sign and zero flags
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k]    <= 31'(34'(mag[k]) * 34'(mag[k]));
        neg_a_q[k] <= c_i[k][16];
      end
      vsq_q     <= sq_q;
      s_q       <= s_d;
      side_q[0] <= {(s_d == 32'd0), neg_a_q};
      for (int i = 1; i <= SIDE_DLY; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  dtsb_div3 u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .vsq_i (vsq_q),
    .s_i   (s_q),
    .q_o   (quo)
  );

  dtsb_isqrt3 u_sqrt (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (quo),
    .m_o   (root)
  );

  // unit magnitude is the largest r with (2r-1)^2 <= quotient
  always_ff @(posedge clk_i) begin
    logic [16:0] r;
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        r = 17'(({1'b0, root[k]} + 17'd1) >> 1);
        if (side_q[SIDE_DLY][3]) begin
          u_q[k] <= '0;
        end else if (side_q[SIDE_DLY][k]) begin
          u_q[k] <= s16_t'(-$signed(r[15:0]));
        end else begin
          u_q[k] <= s16_t'(r[15:0]);
        end
      end
    end
  end

  assign u_o = u_q;

endmodule

// ----- rtl/core/direction_to_scaled_basis_matrix_core.sv -----
// scaled look-at basis: one transaction in, one transaction out, and a
// new direction accepted in every cycle; the depth comes from the two vector normalizers,
// each a 31-stage restoring divider followed by a 16-stage square root, plus the cross
// product, shift and scaling stages; when the output transaction is not taken the whole
// pipeline holds, so throughput is one item per cycle whenever the sink keeps up
module direction_to_scaled_basis_matrix_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtsb_in_if.sink   in_i,
  dtsb_out_if.source out_o
);
  import dtsb_pkg::*;

  // delay taps for the side data that skips the normalizers
  localparam int SC_DLY = 2 * NORM_LAT + 3;
  localparam int FW_DLY = NORM_LAT + 3;

  logic en;
  logic vld_q [TOTAL_LAT];

  // global advance: everything moves unless a finished result is stuck
  assign en         = !vld_q[TOTAL_LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TOTAL_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      for (int i = 1; i < TOTAL_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // front axis: normalize the raw direction
  cmp_t dir_c [3];
  s16_t fw1 [3];

  assign dir_c[0] = 17'(in_i.data.dir_x);
  assign dir_c[1] = 17'(in_i.data.dir_y);
  assign dir_c[2] = 17'(in_i.data.dir_z);

  dtsb_norm3 u_norm_front (
    .clk_i (clk_i),
    .en_i  (en),
    .c_i   (dir_c),
    .u_o   (fw1)
  );

  // scales ride along until the row multipliers
  s16_t sc_dly_q [SC_DLY][3];
  s16_t fw_dly_q [FW_DLY][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_dly_q[0][0] <= in_i.data.scale_x;
      sc_dly_q[0][1] <= in_i.data.scale_y;
      sc_dly_q[0][2] <= in_i.data.scale_z;
      for (int i = 1; i < SC_DLY; i++) begin
        sc_dly_q[i] <= sc_dly_q[i-1];
      end
      fw_dly_q[0] <= fw1;
      for (int i = 1; i < FW_DLY; i++) begin
        fw_dly_q[i] <= fw_dly_q[i-1];
      end
    end
  end

  // tilted up cross front, exact in q2.28
  logic signed [29:0] rc_d [3];
  logic signed [29:0] rc_q [3];

  always_comb begin
    rc_d[0] = 30'(fw1[2]) * 30'(TILT_UY);
    rc_d[1] = -(30'(fw1[2]) * 30'(TILT_UX));
    rc_d[2] = 30'(fw1[1]) * 30'(TILT_UX) - 30'(fw1[0]) * 30'(TILT_UY);
  end

  // magnitudes and the largest of them
  logic [28:0] rmag_d [3];
  logic [28:0] rmag_q [3];
  logic [2:0]  rneg_q;
  logic [28:0] big_d;
  logic [28:0] big_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rmag_d[k] = rc_q[k][29] ? 29'(-rc_q[k]) : 29'(rc_q[k]);
    end
    big_d = rmag_d[0];
    if (rmag_d[1] > big_d) begin
      big_d = rmag_d[1];
    end
    if (rmag_d[2] > big_d) begin
      big_d = rmag_d[2];
    end
  end

  // common right shift that brings the largest magnitude into 15 bits
  logic [3:0]  sh;
  logic [14:0] rsh [3];
  cmp_t        rn_q [3];

  always_comb begin
    sh = 4'd15;
    for (int s = 15; s >= 0; s--) begin
      if ((big_q >> s) <= 29'd32767) begin
        sh = 4'(s);
      end
    end
    for (int k = 0; k < 3; k++) begin
      rsh[k] = 15'(rmag_q[k] >> sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rc_q   <= rc_d;
      rmag_q <= rmag_d;
      big_q  <= big_d;
      for (int k = 0; k < 3; k++) begin
        rneg_q[k] <= rc_q[k][29];
        rn_q[k]   <= rneg_q[k] ? -$signed({2'b00, rsh[k]}) : $signed({2'b00, rsh[k]});
      end
    end
  end

  // right axis: normalize the shifted cross product
  s16_t rt [3];

  dtsb_norm3 u_norm_right (
    .clk_i (clk_i),
    .en_i  (en),
    .c_i   (rn_q),
    .u_o   (rt)
  );

  // up axis: front cross right, partial products first
  logic signed [31:0] up_p_q [6];
  s16_t               fw_u1_q [3];
  s16_t               rt_u1_q [3];
  s16_t               sc_u1_q [3];
  s16_t               fw_u2_q [3];
  s16_t               rt_u2_q [3];
  s16_t               sc_u2_q [3];
  s16_t               up_q [3];
  s16_t               fw_t [3];

  assign fw_t = fw_dly_q[FW_DLY-1];

  // round q2.28 to q1.14, tie away from zero, clamp to unit range
  function automatic s16_t up_round(input logic signed [32:0] v);
    logic [32:0] m;
    logic [18:0] r;
    m = v[32] ? 33'(-v) : 33'(v);
    r = 19'((m + 33'(ROUND_HALF)) >> 14);
    if (r > 19'(Q14_ONE)) begin
      r = 19'(Q14_ONE);
    end
    return v[32] ? s16_t'(-$signed({1'b0, r[14:0]})) : s16_t'({1'b0, r[14:0]});
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      up_p_q[0] <= 32'(fw_t[1]) * 32'(rt[2]);
      up_p_q[1] <= 32'(fw_t[2]) * 32'(rt[1]);
      up_p_q[2] <= 32'(fw_t[2]) * 32'(rt[0]);
      up_p_q[3] <= 32'(fw_t[0]) * 32'(rt[2]);
      up_p_q[4] <= 32'(fw_t[0]) * 32'(rt[1]);
      up_p_q[5] <= 32'(fw_t[1]) * 32'(rt[0]);
      fw_u1_q   <= fw_t;
      rt_u1_q   <= rt;
      sc_u1_q   <= sc_dly_q[SC_DLY-1];

      up_q[0] <= up_round(33'(up_p_q[0]) - 33'(up_p_q[1]));
      up_q[1] <= up_round(33'(up_p_q[2]) - 33'(up_p_q[3]));
      up_q[2] <= up_round(33'(up_p_q[4]) - 33'(up_p_q[5]));
      fw_u2_q <= fw_u1_q;
      rt_u2_q <= rt_u1_q;
      sc_u2_q <= sc_u1_q;
    end
  end

  // rows: axis times scale, q8.8 with rounding and saturation
  logic signed [31:0] row_p_q [9];
  s16_t               fw_m1_q [3];
  dtsb_out_t          out_q;

  function automatic s16_t row_round(input logic signed [31:0] p);
    logic [31:0] m;
    logic [17:0] r;
    m = p[31] ? 32'(-p) : 32'(p);
    r = 18'((m + 32'(ROUND_HALF)) >> 14);
    if (p[31]) begin
      return (r > 18'd32768) ? s16_t'(16'h8000) : s16_t'(-$signed({1'b0, r[15:0]}));
    end
    return (r > 18'd32767) ? s16_t'(16'h7fff) : s16_t'(r[15:0]);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        row_p_q[k]     <= 32'(rt_u2_q[k]) * 32'(sc_u2_q[0]);
        row_p_q[3 + k] <= 32'(up_q[k]) * 32'(sc_u2_q[1]);
        row_p_q[6 + k] <= 32'(fw_u2_q[k]) * 32'(sc_u2_q[2]);
      end
      fw_m1_q <= fw_u2_q;

      out_q.m_right_x    <= row_round(row_p_q[0]);
      out_q.m_right_y    <= row_round(row_p_q[1]);
      out_q.m_right_z    <= row_round(row_p_q[2]);
      out_q.m_up_x       <= row_round(row_p_q[3]);
      out_q.m_up_y       <= row_round(row_p_q[4]);
      out_q.m_up_z       <= row_round(row_p_q[5]);
      out_q.m_front_x    <= row_round(row_p_q[6]);
      out_q.m_front_y    <= row_round(row_p_q[7]);
      out_q.m_front_z    <= row_round(row_p_q[8]);
      out_q.unit_front_x <= fw_m1_q[0];
      out_q.unit_front_y <= fw_m1_q[1];
      out_q.unit_front_z <= fw_m1_q[2];
    end
  end

  assign out_o.valid = vld_q[TOTAL_LAT-1];
  assign out_o.data  = out_q;

  // a stuck result blocks new transactions
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while output stalled");

  // unit front stays inside the q1.14 unit range
  a_front_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_q.unit_front_x <= 16'sd16384 && out_q.unit_front_x >= -16'sd16384 &&
                     out_q.unit_front_y <= 16'sd16384 && out_q.unit_front_y >= -16'sd16384 &&
                     out_q.unit_front_z <= 16'sd16384 && out_q.unit_front_z >= -16'sd16384))
    else $error("unit front out of range");

  // a zero front only comes from a zero direction, which clears every row
  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_q.unit_front_x == 0 && out_q.unit_front_y == 0 &&
     out_q.unit_front_z == 0) |->
    (out_q.m_right_x == 0 && out_q.m_right_y == 0 && out_q.m_right_z == 0 &&
     out_q.m_up_x == 0 && out_q.m_up_y == 0 && out_q.m_up_z == 0 &&
     out_q.m_front_x == 0 && out_q.m_front_y == 0 && out_q.m_front_z == 0))
    else $error("zero direction gave nonzero rows");

endmodule

// ----- bench/direction_to_scaled_basis_matrix_core_test.sv -----
`timescale 1ns / 100ps

module direction_to_scaled_basis_matrix_core_test;
  import dtsb_pkg::*;

  logic clk_i;
  logic rst_ni;

  dtsb_in_if  in_bus ();
  dtsb_out_if out_bus ();

  direction_to_scaled_basis_matrix_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  // 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // round(v * 2^14 / sqrt(s)) with exact integer comparison, ties away from zero
  function automatic longint unsigned unit_mag(longint unsigned v, longint unsigned s);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned rhs;
    lo  = 0;
    hi  = Q14_ONE;
    rhs = v * v * (64'd1 << 28);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (lo < Q14_ONE && (2 * lo + 1) * (2 * lo + 1) * s <= 4 * rhs) lo++;
    return lo;
  endfunction

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // normalize a vector whose components are at most 32768 in magnitude
  function automatic void to_unit(input longint c[3], output longint u[3]);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < 3; i++) s += magn(c[i]) * magn(c[i]);
    for (int i = 0; i < 3; i++) begin
      if (s == 0) u[i] = 0;
      else u[i] = (c[i] < 0) ? -longint'(unit_mag(magn(c[i]), s))
                             : longint'(unit_mag(magn(c[i]), s));
    end
  endfunction

  // drop 14 fraction bits, rounding half away from zero
  function automatic longint round_q14(longint v);
    longint unsigned m;
    m = (magn(v) + (64'd1 << 13)) >> 14;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // full basis computation for one direction and scale set
  function automatic dtsb_out_t basis_of(dtsb_in_t a);
    longint dir[3];
    longint fw[3];
    longint rc[3];
    longint rt[3];
    longint uc[3];
    longint ax[3][3];
    longint scl[3];
    longint unsigned big;
    int sh;
    logic signed [15:0] flat[12];
    dtsb_out_t r;
    dir = '{longint'(a.dir_x), longint'(a.dir_y), longint'(a.dir_z)};
    scl = '{longint'(a.scale_x), longint'(a.scale_y), longint'(a.scale_z)};
    to_unit(dir, fw);
    // tilted up cross front
    rc[0] = longint'(TILT_UY) * fw[2];
    rc[1] = -longint'(TILT_UX) * fw[2];
    rc[2] = longint'(TILT_UX) * fw[1] - longint'(TILT_UY) * fw[0];
    big = 0;
    for (int i = 0; i < 3; i++) if (magn(rc[i]) > big) big = magn(rc[i]);
    sh = 0;
    while ((big >> sh) > 32767) sh++;
    for (int i = 0; i < 3; i++)
      rc[i] = (rc[i] < 0) ? -longint'(magn(rc[i]) >> sh) : longint'(magn(rc[i]) >> sh);
    to_unit(rc, rt);
    uc[0] = fw[1] * rt[2] - fw[2] * rt[1];
    uc[1] = fw[2] * rt[0] - fw[0] * rt[2];
    uc[2] = fw[0] * rt[1] - fw[1] * rt[0];
    for (int i = 0; i < 3; i++) begin
      ax[0][i] = rt[i];
      ax[1][i] = clip(round_q14(uc[i]), -Q14_ONE, Q14_ONE);
      ax[2][i] = fw[i];
    end
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++)
        flat[j * 3 + i] = 16'(clip(round_q14(ax[j][i] * scl[j]), -32768, 32767));
    for (int i = 0; i < 3; i++) flat[9 + i] = 16'(fw[i]);
    r = {flat[0], flat[1], flat[2], flat[3], flat[4], flat[5],
         flat[6], flat[7], flat[8], flat[9], flat[10], flat[11]};
    return r;
  endfunction

  // holds predicted bases in order and compares arriving rows
  class basis_board;
    dtsb_out_t pending[$];
    int        errors;
    int        checked;

    function void note_direction(dtsb_in_t a);
      pending.push_back(basis_of(a));
    endfunction

    function void check_basis(dtsb_out_t got);
      dtsb_out_t want;
      logic [15:0] w;
      logic [15:0] g;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      // twelve 16-bit fields, m_right_x in the top slice
      for (int k = 0; k < 12; k++) begin
        w = want[(11 - k) * 16 +: 16];
        g = got[(11 - k) * 16 +: 16];
        if (w !== g) begin
          $display("%0t: field %0d expected %0d actual %0d", $time, k,
                   $signed(w), $signed(g));
          errors++;
        end
      end
    endfunction
  endclass

  basis_board board;
  bit         calm;       // no idling in the last part of the run
  bit         feed_done;
  int         sent;
  int         in_gap;
  int         out_gap;

  // random direction: mostly full range, some small vectors, some near the tilted up axis
  function automatic dtsb_in_t rand_item();
    dtsb_in_t a;
    int kind;
    a = '{default: '0};
    kind = $urandom_range(0, 9);
    a.dir_x = 16'($urandom);
    a.dir_y = 16'($urandom);
    a.dir_z = 16'($urandom);
    if (kind < 2) begin
      a.dir_x = 16'($signed($urandom_range(0, 8)) - 4);
      a.dir_y = 16'($signed($urandom_range(0, 8)) - 4);
      a.dir_z = 16'($signed($urandom_range(0, 8)) - 4);
    end else if (kind == 2) begin
      // close to the y axis, so right comes from the tiny tilt
      a.dir_x = 16'($signed($urandom_range(0, 4)) - 2);
      a.dir_z = 16'($signed($urandom_range(0, 2)) - 1);
    end
    a.scale_x = 16'($urandom);
    a.scale_y = 16'($urandom);
    a.scale_z = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      // moderate scales so rows do not always saturate
      a.scale_x = 16'($signed($urandom_range(0, 1024)) - 512);
      a.scale_y = 16'($signed($urandom_range(0, 1024)) - 512);
      a.scale_z = 16'($signed($urandom_range(0, 1024)) - 512);
    end
    return a;
  endfunction

  // offer one transaction and wait for its acceptance
  task automatic send_dir(dtsb_in_t a);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_gap = $urandom_range(1, 5);
      in_bus.valid <= 1'b0;
      repeat (in_gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= a;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    board.note_direction(a);
    sent++;
  endtask

  task automatic mk_send(int x, int y, int z, int sx, int sy, int sz);
    dtsb_in_t a;
    a.dir_x   = 16'(x);
    a.dir_y   = 16'(y);
    a.dir_z   = 16'(z);
    a.scale_x = 16'(sx);
    a.scale_y = 16'(sy);
    a.scale_z = 16'(sz);
    send_dir(a);
  endtask

  // sink side: random stall bursts, none once calm
  initial begin
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) board.check_basis(out_bus.data);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_gap = $urandom_range(1, 5);
        out_bus.ready <= 1'b0;
        repeat (out_gap) begin
          @(posedge clk_i);
          if (out_bus.valid && out_bus.ready) board.check_basis(out_bus.data);
        end
      end
      out_bus.ready <= 1'b1;
    end
  end

  initial begin
    board        = new();
    calm         = 1'b0;
    feed_done    = 1'b0;
    sent         = 0;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    rst_ni       = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero direction, axis directions, field extremes, front on the tilted up axis
    mk_send(0, 0, 0, 32767, -32768, 256);
    mk_send(0, 32767, 0, 256, 256, 256);
    mk_send(0, -32768, 0, 256, 256, 256);
    mk_send(1, 1024, 0, 256, -256, 256);     // exactly along tilted up: no right axis
    mk_send(-1, -1024, 0, 32767, 32767, 32767);
    mk_send(32767, 0, 0, 256, 256, 256);
    mk_send(-32768, 0, 0, -32768, -32768, -32768);
    mk_send(0, 0, 32767, 32767, 32767, 32767);
    mk_send(0, 0, -32768, -1, -1, -1);
    mk_send(-32768, -32768, -32768, 32767, -32768, 1);
    mk_send(32767, 32767, 32767, -32768, 32767, -1);
    mk_send(-32768, 32767, -32768, 128, 128, 128);
    mk_send(1, 1, 1, 0, 0, 0);
    mk_send(-1, 0, 0, 1, 1, 1);
    mk_send(0, 0, 1, 12345, -12345, 300);
    mk_send(0, 1, 1, 512, 512, 512);
    mk_send(0, 1, 0, -32768, -32768, -32768);
    mk_send(3, -4, 0, 256, 256, 256);
    mk_send(21845, -21846, 10923, 32767, -1, -32768);

    repeat (1000) begin
      if (sent >= 900) calm = 1'b1;
      send_dir(rand_item());
    end
    in_bus.valid <= 1'b0;
    feed_done = 1'b1;
  end

  // drain, then idle quietly before the summary
  initial begin
    wait (feed_done === 1'b1);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (TOTAL_LAT + 20) @(posedge clk_i);
    $display("covered %0d directions incl. zero, axis-aligned, tilt-parallel and extreme scales",
             sent);
    $display("%0d results compared with random stalls on both sides", board.checked);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
